FILE: rtl/partitioned_posting_table_unit_assert.svh
// Assertion helpers shared by the RTL.
`ifndef PARTITIONED_POSTING_TABLE_UNIT_ASSERT_SVH
`define PARTITIONED_POSTING_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PPT_CHECK(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ppt check failed");

// Next-cycle implication.
`define PPT_CHECK_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ppt check failed");

`endif

FILE: rtl/ppt_pkg.sv
package ppt_pkg;

   localparam int HASH_W     = 32;
   localparam int BIT_CNT_W  = $clog2(HASH_W);
   localparam int HASH_SHIFT = 5;
   localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;

   localparam int NODE_CNT_W = 9;
   localparam int NODE_ID_W  = 8;
   localparam logic [NODE_CNT_W-1:0] MAX_NODES = 9'd256;

   localparam int BYTE_W    = 8;
   localparam int DOC_W     = 31;
   localparam int FREQ_W    = 16;
   localparam int HFREQ_W   = 32;
   localparam int TOTAL_W   = 5;

   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   localparam logic CSR_NODE_COUNT = 1'b0;
   localparam logic CSR_NODE_ID    = 1'b1;

   typedef enum logic [3:0] {
      RS_FORWARD,
      RS_FREQ_ADDED,
      RS_APPENDED,
      RS_POST_FULL,
      RS_CREATED,
      RS_TABLE_FULL,
      RS_HIT,
      RS_MISS,
      RS_REMOTE
   } status_type;

   typedef struct packed {
      logic              cmd;
      logic [BYTE_W-1:0] term_byte;
      logic              term_last;
      logic [DOC_W-1:0]  doc_id;
      logic [FREQ_W-1:0] freq;
   } req_word_type;

   typedef struct packed {
      status_type           status;
      logic [NODE_ID_W-1:0] owner;
      logic [TOTAL_W-1:0]   posting_total;
      logic [DOC_W-1:0]     hit_doc;
      logic [HFREQ_W-1:0]   hit_freq;
      logic                 last_result;
   } rsp_word_type;

   typedef struct packed {
      logic                 cmd;
      logic                 is_local;
      logic [NODE_ID_W-1:0] owner;
      logic [DOC_W-1:0]     doc_id;
      logic [FREQ_W-1:0]    freq;
   } job_type;

   typedef enum logic {
      F_ACCEPT,
      F_DIVIDE
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_ENT_RD,
      B_ENT_CHK,
      B_BYTE_RD,
      B_BYTE_CHK,
      B_FOUND,
      B_POST_RD,
      B_POST_CHK,
      B_APPEND,
      B_NOT_FOUND,
      B_COPY_RD,
      B_COPY_WR,
      B_CREATE,
      B_HIT_RD,
      B_HIT_EMIT,
      B_EMIT
   } back_state_type;

endpackage

FILE: rtl/ppt_front.sv
module ppt_front #(
   parameter int TERM_BYTES = 32,
   parameter int LEN_W      = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  ppt_pkg::req_word_type req_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [8:0]            csr_wdata,
   input  logic                  q_space,
   output logic                  tw_en,
   output logic [LEN_W-1:0]      tw_idx,
   output logic [7:0]            tw_data,
   output logic                  jp_en,
   output ppt_pkg::job_type      jp_job,
   output logic [LEN_W-1:0]      jp_len
);
   import ppt_pkg::*;

   localparam logic [LEN_W-1:0]     LEN_MAX  = LEN_W'(TERM_BYTES - 1);
   localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(HASH_W - 1);

   front_state_type        state_ff, state_in;
   logic [HASH_W-1:0]      hash_ff, hash_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [BIT_CNT_W-1:0]   bit_ff, bit_in;
   logic [NODE_ID_W-1:0]   rem_ff, rem_in;
   job_type                job_ff, job_in;
   logic [NODE_CNT_W-1:0]  nc_ff;
   logic [NODE_ID_W-1:0]   nid_ff;

   logic                   accept;
   logic [NODE_CNT_W-1:0]  nodes;
   logic [NODE_CNT_W-1:0]  trial;
   logic [NODE_ID_W-1:0]   rem_next;

   assign csr_ready = 1'b1;
   assign full      = !(state_ff == F_ACCEPT && q_space);
   assign accept    = push && !full;
   assign tw_idx    = len_ff;
   assign tw_data   = req_word.term_byte;
   assign jp_len    = len_ff;

   always_comb begin
      if (nc_ff == '0) begin
         nodes = NODE_CNT_W'(1);
      end else if (nc_ff > MAX_NODES) begin
         nodes = MAX_NODES;
      end else begin
         nodes = nc_ff;
      end
      trial = {rem_ff, hash_ff[HASH_W-1]};
      if (trial >= nodes) begin
         rem_next = NODE_ID_W'(trial - nodes);
      end else begin
         rem_next = trial[NODE_ID_W-1:0];
      end
   end

   always_comb begin
      jp_job          = job_ff;
      jp_job.owner    = rem_next;
      jp_job.is_local = (rem_next == nid_ff);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_ACCEPT: begin
            if (accept && req_word.term_last) begin
               state_in = F_DIVIDE;
            end
         end
         F_DIVIDE: begin
            if (bit_ff == BIT_LAST) begin
               state_in = F_ACCEPT;
            end
         end
         default: state_in = F_ACCEPT;
      endcase
   end

   always_comb begin
      hash_in = hash_ff;
      len_in  = len_ff;
      bit_in  = bit_ff;
      rem_in  = rem_ff;
      job_in  = job_ff;
      tw_en   = 1'b0;
      jp_en   = 1'b0;
      case (state_ff)
         F_ACCEPT: begin
            if (accept) begin
               hash_in = (hash_ff << HASH_SHIFT) + hash_ff + HASH_W'(req_word.term_byte);
               if (len_ff < LEN_MAX) begin
                  tw_en  = 1'b1;
                  len_in = len_ff + LEN_W'(1);
               end
               if (req_word.term_last) begin
                  job_in.cmd    = req_word.cmd;
                  job_in.doc_id = req_word.doc_id;
                  job_in.freq   = req_word.freq;
                  bit_in        = '0;
                  rem_in        = '0;
               end
            end
         end
         F_DIVIDE: begin
            hash_in = hash_ff << 1;
            rem_in  = rem_next;
            bit_in  = bit_ff + BIT_CNT_W'(1);
            if (bit_ff == BIT_LAST) begin
               jp_en   = 1'b1;
               hash_in = HASH_SEED;
               len_in  = '0;
            end
         end
         default: begin
            hash_in = HASH_SEED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_ACCEPT;
         hash_ff  <= HASH_SEED;
         len_ff   <= '0;
         bit_ff   <= '0;
         nc_ff    <= NODE_CNT_W'(1);
         nid_ff   <= '0;
      end else begin
         state_ff <= state_in;
         hash_ff  <= hash_in;
         len_ff   <= len_in;
         bit_ff   <= bit_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NODE_COUNT: nc_ff  <= csr_wdata;
               CSR_NODE_ID:    nid_ff <= csr_wdata[NODE_ID_W-1:0];
               default:        nc_ff  <= nc_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      job_ff <= job_in;
   end

endmodule

FILE: rtl/ppt_queue.sv
`include "partitioned_posting_table_unit_assert.svh"

module ppt_queue #(
   parameter int LEN_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             tw_en,
   input  logic [LEN_W-1:0] tw_idx,
   input  logic [7:0]       tw_data,
   input  logic             jp_en,
   input  ppt_pkg::job_type jp_job,
   input  logic [LEN_W-1:0] jp_len,
   output logic             q_space,
   output logic             head_valid,
   output ppt_pkg::job_type head_job,
   output logic [LEN_W-1:0] head_len,
   input  logic             pop_job,
   input  logic             tr_en,
   input  logic [LEN_W-1:0] tr_idx,
   output logic [7:0]       tr_data
);
   import ppt_pkg::*;

   localparam int TMEM_D = 2 * (2 ** LEN_W);

   logic [7:0]       term_mem [TMEM_D];
   logic [7:0]       tr_data_ff;
   job_type          job_slot_ff [2];
   logic [LEN_W-1:0] len_slot_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       cnt_ff, cnt_in;

   assign q_space    = (cnt_ff != 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head_job   = job_slot_ff[rd_ptr_ff];
   assign head_len   = len_slot_ff[rd_ptr_ff];
   assign tr_data    = tr_data_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (jp_en && !pop_job) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!jp_en && pop_job) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (tw_en) begin
         term_mem[{wr_ptr_ff, tw_idx}] <= tw_data;
      end
      if (tr_en) begin
         tr_data_ff <= term_mem[{rd_ptr_ff, tr_idx}];
      end
      if (jp_en) begin
         job_slot_ff[wr_ptr_ff] <= jp_job;
         len_slot_ff[wr_ptr_ff] <= jp_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (jp_en) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop_job) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   `PPT_CHECK(a_push_room, jp_en, cnt_ff != 2'd2)
   `PPT_CHECK(a_pop_held, pop_job, cnt_ff != 2'd0)
   `PPT_CHECK_NEXT(a_push_count, jp_en && !pop_job, cnt_ff == $past(cnt_ff) + 2'd1)

endmodule

FILE: rtl/ppt_back.sv
`include "partitioned_posting_table_unit_assert.svh"

module ppt_back #(
   parameter int TERM_BYTES   = 32,
   parameter int MAX_POSTINGS = 16,
   parameter int MAX_TERMS    = 256,
   parameter int LEN_W        = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  ppt_pkg::job_type      head_job,
   input  logic [LEN_W-1:0]      head_len,
   output logic                  pop_job,
   output logic                  tr_en,
   output logic [LEN_W-1:0]      tr_idx,
   input  logic [7:0]            tr_data,
   output logic                  empty,
   input  logic                  pop,
   output ppt_pkg::rsp_word_type rsp_word
);
   import ppt_pkg::*;

   localparam int EC_W  = $clog2(MAX_TERMS + 1);
   localparam int EI_W  = $clog2(MAX_TERMS);
   localparam int CNT_W = $clog2(MAX_POSTINGS + 1);
   localparam int PI_W  = (MAX_POSTINGS > 1) ? $clog2(MAX_POSTINGS) : 1;
   localparam int ST_D  = MAX_TERMS * (2 ** LEN_W);
   localparam int PO_D  = MAX_TERMS * (2 ** PI_W);

   logic [7:0]         sterm_mem [ST_D];
   logic [LEN_W-1:0]   len_mem   [MAX_TERMS];
   logic [CNT_W-1:0]   cnt_mem   [MAX_TERMS];
   logic [DOC_W-1:0]   doc_mem   [PO_D];
   logic [HFREQ_W-1:0] frq_mem   [PO_D];

   logic [7:0]         sterm_rd_ff;
   logic [LEN_W-1:0]   len_rd_ff;
   logic [CNT_W-1:0]   cnt_rd_ff;
   logic [DOC_W-1:0]   doc_rd_ff;
   logic [HFREQ_W-1:0] frq_rd_ff;

   back_state_type     state_ff, state_in;
   logic [EC_W-1:0]    ent_ff, ent_in;
   logic [EC_W-1:0]    ec_ff, ec_in;
   logic [LEN_W-1:0]   byte_ff, byte_in;
   logic [CNT_W-1:0]   post_ff, post_in;
   rsp_word_type       res_ff, res_in;
   rsp_word_type       out_ff, out_in;
   logic               out_valid_ff;

   logic               lk_re, st_re, st_we, po_re, doc_we, frq_we, len_we, cnt_we;
   logic [EI_W-1:0]    cnt_wa;
   logic [CNT_W-1:0]   cnt_wd;
   logic [EI_W+PI_W-1:0] po_wa;
   logic [DOC_W-1:0]   doc_wd;
   logic [HFREQ_W-1:0] frq_wd;
   logic               out_load;

   logic [EI_W-1:0]    ent_idx, ec_idx;
   logic               slot_free, hit_last;
   logic [HFREQ_W:0]   sum_wide;
   logic [HFREQ_W-1:0] sum_sat;

   assign ent_idx   = ent_ff[EI_W-1:0];
   assign ec_idx    = ec_ff[EI_W-1:0];
   assign slot_free = !out_valid_ff || pop;
   assign hit_last  = (post_ff + CNT_W'(1)) == cnt_rd_ff;
   assign sum_wide  = {1'b0, frq_rd_ff} + (HFREQ_W + 1)'(head_job.freq);
   assign sum_sat   = sum_wide[HFREQ_W] ? '1 : sum_wide[HFREQ_W-1:0];
   assign tr_idx    = byte_ff;
   assign empty     = !out_valid_ff;
   assign rsp_word  = out_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (head_valid) begin
               state_in = head_job.is_local ? B_ENT_RD : B_EMIT;
            end
         end
         B_ENT_RD:    state_in = (ent_ff == ec_ff) ? B_NOT_FOUND : B_ENT_CHK;
         B_ENT_CHK:   state_in = (len_rd_ff == head_len) ? B_BYTE_RD : B_ENT_RD;
         B_BYTE_RD:   state_in = (byte_ff == head_len) ? B_FOUND : B_BYTE_CHK;
         B_BYTE_CHK:  state_in = (sterm_rd_ff == tr_data) ? B_BYTE_RD : B_ENT_RD;
         B_FOUND: begin
            if (head_job.cmd == CMD_SEARCH) begin
               state_in = (cnt_rd_ff == '0) ? B_EMIT : B_HIT_RD;
            end else begin
               state_in = B_POST_RD;
            end
         end
         B_POST_RD:   state_in = (post_ff == cnt_rd_ff) ? B_APPEND : B_POST_CHK;
         B_POST_CHK:  state_in = (doc_rd_ff == head_job.doc_id) ? B_EMIT : B_POST_RD;
         B_APPEND:    state_in = B_EMIT;
         B_NOT_FOUND: begin
            if (head_job.cmd == CMD_ADD && ec_ff < EC_W'(MAX_TERMS)) begin
               state_in = B_COPY_RD;
            end else begin
               state_in = B_EMIT;
            end
         end
         B_COPY_RD:   state_in = (byte_ff == head_len) ? B_CREATE : B_COPY_WR;
         B_COPY_WR:   state_in = B_COPY_RD;
         B_CREATE:    state_in = B_EMIT;
         B_HIT_RD:    state_in = B_HIT_EMIT;
         B_HIT_EMIT: begin
            if (slot_free) begin
               state_in = hit_last ? B_IDLE : B_HIT_RD;
            end
         end
         B_EMIT: begin
            if (slot_free) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      ent_in   = ent_ff;
      ec_in    = ec_ff;
      byte_in  = byte_ff;
      post_in  = post_ff;
      res_in   = res_ff;
      out_in   = res_ff;
      out_load = 1'b0;
      pop_job  = 1'b0;
      lk_re    = 1'b0;
      st_re    = 1'b0;
      st_we    = 1'b0;
      po_re    = 1'b0;
      doc_we   = 1'b0;
      frq_we   = 1'b0;
      len_we   = 1'b0;
      cnt_we   = 1'b0;
      tr_en    = 1'b0;
      cnt_wa   = ent_idx;
      cnt_wd   = cnt_rd_ff;
      po_wa    = {ent_idx, post_ff[PI_W-1:0]};
      doc_wd   = head_job.doc_id;
      frq_wd   = HFREQ_W'(head_job.freq);
      res_in.owner       = head_job.owner;
      res_in.last_result = 1'b1;
      case (state_ff)
         B_IDLE: begin
            ent_in = '0;
            if (head_job.cmd == CMD_ADD) begin
               res_in.status        = RS_FORWARD;
               res_in.posting_total = '0;
               res_in.hit_doc       = head_job.doc_id;
               res_in.hit_freq      = HFREQ_W'(head_job.freq);
            end else begin
               res_in.status        = RS_REMOTE;
               res_in.posting_total = '0;
               res_in.hit_doc       = '0;
               res_in.hit_freq      = '0;
            end
         end
         B_ENT_RD: begin
            lk_re = (ent_ff != ec_ff);
         end
         B_ENT_CHK: begin
            if (len_rd_ff == head_len) begin
               byte_in = '0;
            end else begin
               ent_in = ent_ff + EC_W'(1);
            end
         end
         B_BYTE_RD: begin
            if (byte_ff != head_len) begin
               st_re = 1'b1;
               tr_en = 1'b1;
            end
         end
         B_BYTE_CHK: begin
            if (sterm_rd_ff == tr_data) begin
               byte_in = byte_ff + LEN_W'(1);
            end else begin
               ent_in = ent_ff + EC_W'(1);
            end
         end
         B_FOUND: begin
            post_in              = '0;
            res_in.status        = RS_MISS;
            res_in.posting_total = '0;
            res_in.hit_doc       = '0;
            res_in.hit_freq      = '0;
         end
         B_POST_RD: begin
            po_re = (post_ff != cnt_rd_ff);
         end
         B_POST_CHK: begin
            if (doc_rd_ff == head_job.doc_id) begin
               frq_we               = 1'b1;
               frq_wd               = sum_sat;
               res_in.status        = RS_FREQ_ADDED;
               res_in.posting_total = TOTAL_W'(cnt_rd_ff);
               res_in.hit_doc       = head_job.doc_id;
               res_in.hit_freq      = sum_sat;
            end else begin
               post_in = post_ff + CNT_W'(1);
            end
         end
         B_APPEND: begin
            res_in.hit_doc = head_job.doc_id;
            if (cnt_rd_ff < CNT_W'(MAX_POSTINGS)) begin
               doc_we               = 1'b1;
               frq_we               = 1'b1;
               cnt_we               = 1'b1;
               po_wa                = {ent_idx, cnt_rd_ff[PI_W-1:0]};
               cnt_wd               = cnt_rd_ff + CNT_W'(1);
               res_in.status        = RS_APPENDED;
               res_in.posting_total = TOTAL_W'(cnt_rd_ff + CNT_W'(1));
               res_in.hit_freq      = HFREQ_W'(head_job.freq);
            end else begin
               res_in.status        = RS_POST_FULL;
               res_in.posting_total = TOTAL_W'(cnt_rd_ff);
               res_in.hit_freq      = '0;
            end
         end
         B_NOT_FOUND: begin
            byte_in              = '0;
            res_in.posting_total = '0;
            res_in.hit_freq      = '0;
            if (head_job.cmd == CMD_SEARCH) begin
               res_in.status  = RS_MISS;
               res_in.hit_doc = '0;
            end else begin
               res_in.status  = RS_TABLE_FULL;
               res_in.hit_doc = head_job.doc_id;
            end
         end
         B_COPY_RD: begin
            tr_en = (byte_ff != head_len);
         end
         B_COPY_WR: begin
            st_we   = 1'b1;
            byte_in = byte_ff + LEN_W'(1);
         end
         B_CREATE: begin
            len_we               = 1'b1;
            cnt_we               = 1'b1;
            doc_we               = 1'b1;
            frq_we               = 1'b1;
            cnt_wa               = ec_idx;
            cnt_wd               = CNT_W'(1);
            po_wa                = {ec_idx, PI_W'(0)};
            ec_in                = ec_ff + EC_W'(1);
            res_in.status        = RS_CREATED;
            res_in.posting_total = TOTAL_W'(1);
            res_in.hit_doc       = head_job.doc_id;
            res_in.hit_freq      = HFREQ_W'(head_job.freq);
         end
         B_HIT_RD: begin
            po_re = 1'b1;
         end
         B_HIT_EMIT: begin
            out_in.status        = RS_HIT;
            out_in.owner         = head_job.owner;
            out_in.posting_total = TOTAL_W'(cnt_rd_ff);
            out_in.hit_doc       = doc_rd_ff;
            out_in.hit_freq      = frq_rd_ff;
            out_in.last_result   = hit_last;
            if (slot_free) begin
               out_load = 1'b1;
               post_in  = post_ff + CNT_W'(1);
               pop_job  = hit_last;
            end
         end
         B_EMIT: begin
            if (slot_free) begin
               out_load = 1'b1;
               pop_job  = 1'b1;
            end
         end
         default: begin
            ent_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (lk_re) begin
         len_rd_ff <= len_mem[ent_idx];
         cnt_rd_ff <= cnt_mem[ent_idx];
      end
      if (len_we) begin
         len_mem[ec_idx] <= head_len;
      end
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (st_re) begin
         sterm_rd_ff <= sterm_mem[{ent_idx, byte_ff}];
      end
      if (st_we) begin
         sterm_mem[{ec_idx, byte_ff}] <= tr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (po_re) begin
         doc_rd_ff <= doc_mem[{ent_idx, post_ff[PI_W-1:0]}];
         frq_rd_ff <= frq_mem[{ent_idx, post_ff[PI_W-1:0]}];
      end
      if (doc_we) begin
         doc_mem[po_wa] <= doc_wd;
      end
      if (frq_we) begin
         frq_mem[po_wa] <= frq_wd;
      end
   end

   always_ff @(posedge clock) begin
      res_ff   <= res_in;
      byte_ff  <= byte_in;
      post_ff  <= post_in;
      ent_ff   <= ent_in;
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         ec_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ec_ff    <= ec_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   `PPT_CHECK(a_no_overwrite, out_load, !out_valid_ff || pop)
   `PPT_CHECK(a_table_bound, 1'b1, ec_ff <= EC_W'(MAX_TERMS))
   `PPT_CHECK(a_pop_with_job, pop_job, head_valid && out_load)

endmodule

FILE: rtl/partitioned_posting_table_unit.sv
// Channel   Handshake              Word             Moves
// req       push / full            req_word_type    one term byte per word
// rsp       empty / pop            rsp_word_type    one result per word
// csr       csr_valid / csr_ready  csr_index, data  node_count, node_id
//
// Front: takes one byte per cycle while not full, then reduces the hash by
// node count bit by bit. Back: scans entries, matched bytes and postings,
// copies the bytes of a new term, and emits one word per search hit.
// A two-deep job queue with term banks lets the front run ahead of the back.
// Reset is synchronous; the tables need no clearing pass after reset.
module partitioned_posting_table_unit #(
   parameter int TERM_BYTES   = 32,
   parameter int MAX_POSTINGS = 16,
   parameter int MAX_TERMS    = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  ppt_pkg::req_word_type req_word,
   output logic                  empty,
   input  logic                  pop,
   output ppt_pkg::rsp_word_type rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [8:0]            csr_wdata
);
   import ppt_pkg::*;

   localparam int LEN_W = $clog2(TERM_BYTES);

   logic             q_space, tw_en, jp_en, head_valid, pop_job, tr_en;
   logic [LEN_W-1:0] tw_idx, jp_len, head_len, tr_idx;
   logic [7:0]       tw_data, tr_data;
   job_type          jp_job, head_job;

   ppt_front #(
      .TERM_BYTES(TERM_BYTES),
      .LEN_W     (LEN_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_word  (req_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_space   (q_space),
      .tw_en     (tw_en),
      .tw_idx    (tw_idx),
      .tw_data   (tw_data),
      .jp_en     (jp_en),
      .jp_job    (jp_job),
      .jp_len    (jp_len)
   );

   ppt_queue #(
      .LEN_W(LEN_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .tw_en      (tw_en),
      .tw_idx     (tw_idx),
      .tw_data    (tw_data),
      .jp_en      (jp_en),
      .jp_job     (jp_job),
      .jp_len     (jp_len),
      .q_space    (q_space),
      .head_valid (head_valid),
      .head_job   (head_job),
      .head_len   (head_len),
      .pop_job    (pop_job),
      .tr_en      (tr_en),
      .tr_idx     (tr_idx),
      .tr_data    (tr_data)
   );

   ppt_back #(
      .TERM_BYTES  (TERM_BYTES),
      .MAX_POSTINGS(MAX_POSTINGS),
      .MAX_TERMS   (MAX_TERMS),
      .LEN_W       (LEN_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .head_len   (head_len),
      .pop_job    (pop_job),
      .tr_en      (tr_en),
      .tr_idx     (tr_idx),
      .tr_data    (tr_data),
      .empty      (empty),
      .pop        (pop),
      .rsp_word   (rsp_word)
   );

endmodule

FILE: bench/tb_partitioned_posting_table_unit.sv
`timescale 1ns / 1ps

module tb_partitioned_posting_table_unit;
   import ppt_pkg::*;

   localparam int STORED_MAX = 31;
   localparam int MAX_POST   = 16;
   localparam int MAX_ENT    = 256;
   localparam int DRAIN_WAIT = 300;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         push = 1'b0;
   logic         full;
   req_word_type req_word = '0;
   logic         empty;
   logic         pop = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_index = CSR_NODE_COUNT;
   logic [8:0]   csr_wdata = '0;

   partitioned_posting_table_unit uut (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_word(req_word),
      .empty(empty), .pop(pop), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // table model
   bit [8:0]  nodes_reg;
   bit [7:0]  my_node;
   bit [31:0] hash_run;
   bit [7:0]  term_bytes [STORED_MAX];
   int        term_len;
   int        entries;
   bit [7:0]  entry_term [MAX_ENT][STORED_MAX];
   int        entry_len [MAX_ENT];
   int        entry_posts [MAX_ENT];
   bit [30:0] post_doc [MAX_ENT][MAX_POST];
   bit [31:0] post_freq [MAX_ENT][MAX_POST];

   rsp_word_type pending_results[$];
   int errors = 0;
   int results_seen = 0;
   int words_sent = 0;
   int terms_sent = 0;
   int burst_left = 0;

   function automatic rsp_word_type mk(status_type st, bit [7:0] own, bit [4:0] tot,
                                       bit [30:0] doc, bit [31:0] frq, bit lst);
      rsp_word_type r;
      r.status = st;
      r.owner = own;
      r.posting_total = tot;
      r.hit_doc = doc;
      r.hit_freq = frq;
      r.last_result = lst;
      return r;
   endfunction

   function automatic int find_term();
      for (int i = 0; i < entries; i++) begin
         if (entry_len[i] == term_len) begin
            bit same = 1'b1;
            for (int k = 0; k < term_len; k++)
               if (entry_term[i][k] != term_bytes[k]) same = 1'b0;
            if (same) return i;
         end
      end
      return -1;
   endfunction

   function automatic void predict_postings(req_word_type w);
      bit [31:0] nodes;
      bit [31:0] own32;
      bit [7:0]  own;
      bit [31:0] sum;
      int        e;
      int        cnt;
      bit        done;
      hash_run = (hash_run << HASH_SHIFT) + hash_run + 32'(w.term_byte);
      if (term_len < STORED_MAX) begin
         term_bytes[term_len] = w.term_byte;
         term_len++;
      end
      if (!w.term_last) return;
      nodes = 32'(nodes_reg);
      if (nodes == 0) nodes = 1;
      if (nodes > 256) nodes = 256;
      own32 = hash_run % nodes;
      own = own32[7:0];
      e = find_term();
      if (w.cmd == CMD_ADD) begin
         if (own != my_node) begin
            pending_results.push_back(mk(RS_FORWARD, own, 5'd0, w.doc_id, 32'(w.freq),
                                         1'b1));
         end else if (e >= 0) begin
            cnt = entry_posts[e];
            done = 1'b0;
            for (int j = 0; j < cnt && !done; j++) begin
               if (post_doc[e][j] == w.doc_id) begin
                  sum = post_freq[e][j] + 32'(w.freq);
                  if (sum < 32'(w.freq)) sum = 32'hFFFF_FFFF;
                  post_freq[e][j] = sum;
                  pending_results.push_back(mk(RS_FREQ_ADDED, own, 5'(cnt), w.doc_id, sum,
                                               1'b1));
                  done = 1'b1;
               end
            end
            if (!done) begin
               if (cnt < MAX_POST) begin
                  post_doc[e][cnt] = w.doc_id;
                  post_freq[e][cnt] = 32'(w.freq);
                  entry_posts[e] = cnt + 1;
                  pending_results.push_back(mk(RS_APPENDED, own, 5'(cnt + 1), w.doc_id,
                                               32'(w.freq), 1'b1));
               end else begin
                  pending_results.push_back(mk(RS_POST_FULL, own, 5'(cnt), w.doc_id, 32'd0,
                                               1'b1));
               end
            end
         end else if (entries < MAX_ENT) begin
            for (int k = 0; k < term_len; k++) entry_term[entries][k] = term_bytes[k];
            entry_len[entries] = term_len;
            entry_posts[entries] = 1;
            post_doc[entries][0] = w.doc_id;
            post_freq[entries][0] = 32'(w.freq);
            entries++;
            pending_results.push_back(mk(RS_CREATED, own, 5'd1, w.doc_id, 32'(w.freq),
                                         1'b1));
         end else begin
            pending_results.push_back(mk(RS_TABLE_FULL, own, 5'd0, w.doc_id, 32'd0, 1'b1));
         end
      end else begin
         if (own != my_node) begin
            pending_results.push_back(mk(RS_REMOTE, own, 5'd0, 31'd0, 32'd0, 1'b1));
         end else if (e >= 0 && entry_posts[e] > 0) begin
            cnt = entry_posts[e];
            for (int j = 0; j < cnt; j++)
               pending_results.push_back(mk(RS_HIT, own, 5'(cnt), post_doc[e][j],
                                            post_freq[e][j], j + 1 == cnt));
         end else begin
            pending_results.push_back(mk(RS_MISS, own, 5'd0, 31'd0, 32'd0, 1'b1));
         end
      end
      hash_run = HASH_SEED;
      term_len = 0;
      terms_sent++;
   endfunction

   // result checker with its own stall pattern
   int rx_cycle = 0;
   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result word %h", rsp_word);
               errors++;
            end else begin
               exp_w = pending_results.pop_front();
               results_seen++;
               if (rsp_word.status !== exp_w.status) begin
                  $error("status: expected %0d, got %0d", exp_w.status, rsp_word.status);
                  errors++;
               end
               if (rsp_word.owner !== exp_w.owner) begin
                  $error("owner: expected %0d, got %0d", exp_w.owner, rsp_word.owner);
                  errors++;
               end
               if (rsp_word.posting_total !== exp_w.posting_total) begin
                  $error("posting_total: expected %0d, got %0d", exp_w.posting_total,
                         rsp_word.posting_total);
                  errors++;
               end
               if (rsp_word.hit_doc !== exp_w.hit_doc) begin
                  $error("hit_doc: expected %0d, got %0d", exp_w.hit_doc, rsp_word.hit_doc);
                  errors++;
               end
               if (rsp_word.hit_freq !== exp_w.hit_freq) begin
                  $error("hit_freq: expected %0d, got %0d", exp_w.hit_freq,
                         rsp_word.hit_freq);
                  errors++;
               end
               if (rsp_word.last_result !== exp_w.last_result) begin
                  $error("last_result: expected %0d, got %0d", exp_w.last_result,
                         rsp_word.last_result);
                  errors++;
               end
            end
         end
         rx_cycle++;
         case ((rx_cycle >> 7) % 3)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 3) != 0);
            default: pop <= (rx_cycle % 5 == 0);
         endcase
      end
   end

   task automatic send_word(req_word_type w);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         burst_left = $urandom_range(1, 12);
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_word <= w;
      push <= 1'b1;
      do @(posedge clock); while (full);
      predict_postings(w);
      words_sent++;
   endtask

   task automatic send_term(bit cmd, bit [7:0] bytes[$], bit [30:0] doc, bit [15:0] frq);
      req_word_type w;
      for (int k = 0; k < bytes.size(); k++) begin
         w.term_byte = bytes[k];
         w.term_last = (k == bytes.size() - 1);
         if (w.term_last) begin
            w.cmd = cmd;
            w.doc_id = doc;
            w.freq = frq;
         end else begin
            w.cmd = 1'($urandom_range(0, 1));
            w.doc_id = 31'($urandom);
            w.freq = 16'($urandom);
         end
         send_word(w);
      end
   endtask

   task automatic write_csr(logic idx, bit [8:0] val);
      push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_NODE_COUNT) nodes_reg = val;
      else my_node = val[7:0];
   endtask

   task automatic random_terms(int nwords);
      bit [7:0]  vocab [6][$];
      bit [30:0] docs [8];
      bit [7:0]  t[$];
      int        len;
      int        stop_at;
      bit [15:0] f;
      bit [30:0] d;
      for (int v = 0; v < 6; v++) begin
         len = ($urandom_range(0, 5) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 6);
         vocab[v] = {};
         for (int k = 0; k < len; k++) vocab[v].push_back(8'($urandom));
      end
      foreach (docs[i]) docs[i] = 31'($urandom);
      stop_at = words_sent + nwords;
      while (words_sent < stop_at) begin
         if ($urandom_range(0, 4) != 0) begin
            t = vocab[$urandom_range(0, 5)];
         end else begin
            t = {};
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) t.push_back(8'($urandom));
         end
         d = ($urandom_range(0, 9) < 7) ? docs[$urandom_range(0, 7)] : 31'($urandom);
         case ($urandom_range(0, 7))
            0: f = 16'h0000;
            1: f = 16'hFFFF;
            default: f = 16'($urandom);
         endcase
         send_term(1'($urandom_range(0, 1)), t, d, f);
      end
   endtask

   typedef struct {
      bit         cmd;
      int         len;
      bit [7:0]   first;
      bit [30:0]  doc;
      bit [15:0]  frq;
      bit         typed;
      status_type st;
      bit [4:0]   total;
   } term_row;

   term_row plan [11] = '{
      '{CMD_SEARCH, 1,  8'h61, 31'd0,          16'd0,     1'b1, RS_MISS,       5'd0},
      '{CMD_ADD,    1,  8'h61, 31'd0,          16'd0,     1'b1, RS_CREATED,    5'd1},
      '{CMD_ADD,    1,  8'h61, 31'd0,          16'hFFFF,  1'b1, RS_FREQ_ADDED, 5'd1},
      '{CMD_ADD,    1,  8'h61, 31'h7FFF_FFFF,  16'hFFFF,  1'b1, RS_APPENDED,   5'd2},
      '{CMD_SEARCH, 1,  8'h61, 31'd0,          16'd0,     1'b0, RS_HIT,        5'd0},
      '{CMD_ADD,    40, 8'h01, 31'd5,          16'd3,     1'b1, RS_CREATED,    5'd1},
      '{CMD_SEARCH, 40, 8'h01, 31'd0,          16'd0,     1'b0, RS_HIT,        5'd0},
      '{CMD_SEARCH, 35, 8'h01, 31'd0,          16'd0,     1'b0, RS_HIT,        5'd0},
      '{CMD_ADD,    1,  8'h00, 31'd1,          16'd1,     1'b1, RS_CREATED,    5'd1},
      '{CMD_ADD,    1,  8'hFF, 31'd2,          16'd2,     1'b1, RS_CREATED,    5'd1},
      '{CMD_SEARCH, 2,  8'h61, 31'd0,          16'd0,     1'b1, RS_MISS,       5'd0}
   };

   initial begin
      bit [7:0] t[$];
      nodes_reg = 9'd1;
      my_node = 8'd0;
      hash_run = HASH_SEED;
      term_len = 0;
      entries = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[r]) begin
         t = {};
         for (int b = 0; b < plan[r].len; b++) t.push_back(plan[r].first + b[7:0]);
         send_term(plan[r].cmd, t, plan[r].doc, plan[r].frq);
         if (plan[r].typed) begin
            pending_results[$].status = plan[r].st;
            pending_results[$].owner = 8'd0;
            pending_results[$].posting_total = plan[r].total;
         end
      end
      // fill one term's postings, then one past
      for (int n = 0; n <= MAX_POST; n++) send_term(CMD_ADD, '{8'h70}, 31'(100 + n), 16'(n));
      send_term(CMD_SEARCH, '{8'h70}, 31'd0, 16'd0);

      write_csr(CSR_NODE_COUNT, 9'd0);
      write_csr(CSR_NODE_ID, 9'd0);
      random_terms(16);
      write_csr(CSR_NODE_COUNT, 9'd256);
      write_csr(CSR_NODE_ID, 9'd255);
      random_terms(16);
      write_csr(CSR_NODE_COUNT, 9'd511);
      write_csr(CSR_NODE_ID, 9'($urandom_range(0, 255)));
      random_terms(16);
      write_csr(CSR_NODE_COUNT, 9'd3);
      write_csr(CSR_NODE_ID, 9'd2);
      random_terms(16);
      write_csr(CSR_NODE_COUNT, 9'd2);
      write_csr(CSR_NODE_ID, 9'd1);
      random_terms(16);

      push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("covered %0d words in %0d terms, %0d results checked", words_sent, terms_sent,
               results_seen);
      $display("node counts 0..511 incl. clamp, long terms and postings full reached");
      if (errors == 0) begin
         $display("tb_partitioned_posting_table_unit: PASS");
      end else begin
         $display("tb_partitioned_posting_table_unit: FAIL");
      end
      $finish;
   end

   initial begin
      #30ms;
      $display("tb_partitioned_posting_table_unit: FAIL");
      $finish;
   end

endmodule
